### rtl/tcmat_pkg.sv
package tcmat_pkg;

  localparam int WINDOW      = 50;
  localparam int SAMPLE_BITS = 10;
  localparam int CHANNELS    = 3;
  localparam int FRAME_LEN   = 23;
  localparam int DIGITS      = 4;

  localparam int SLOT_W      = $clog2(WINDOW);
  localparam int CNT_W       = $clog2(WINDOW + 1);
  localparam int TOTAL_W     = SAMPLE_BITS + $clog2(WINDOW);
  localparam int BCD_W       = 4 * DIGITS;
  localparam int BIT_CNT_W   = $clog2(SAMPLE_BITS);
  localparam int FRAME_IDX_W = $clog2(FRAME_LEN);

  // exact floor(x / WINDOW) for any TOTAL_W-bit x: (x * RECIP) >> RECIP_SHIFT
  localparam int RECIP_SHIFT = TOTAL_W + $clog2(WINDOW);
  localparam int RECIP_W     = TOTAL_W + 1;
  localparam int PROD_W      = TOTAL_W + RECIP_W;
  localparam longint unsigned RECIP =
    ((64'd1 << RECIP_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'd48;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [TOTAL_W-1:0]     total_t;

  typedef struct packed {
    sample_t pha;
    sample_t rev;
    sample_t fwd;
  } row_t;

  typedef struct packed {
    logic  rd_en;
    slot_t rd_addr;
    logic  wr_en;
    slot_t wr_addr;
    row_t  wr_data;
  } ring_req_t;

  typedef struct packed {
    logic   valid;
    total_t fwd;
    total_t rev;
    total_t pha;
  } frame_req_t;

endpackage

### rtl/tcmat_if.sv
interface tcmat_sample_if;
  logic                 valid;
  logic                 ready;
  tcmat_pkg::sample_t   forward_sample;
  tcmat_pkg::sample_t   reverse_sample;
  tcmat_pkg::sample_t   phase_sample;

  modport source (output valid, output forward_sample, output reverse_sample,
                  output phase_sample, input ready);
  modport sink   (input valid, input forward_sample, input reverse_sample,
                  input phase_sample, output ready);
endinterface

interface tcmat_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

### rtl/tcmat_ring.sv
module tcmat_ring (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tcmat_pkg::ring_req_t  req,
  output tcmat_pkg::row_t       rd_data
);

  tcmat_pkg::row_t            mem [tcmat_pkg::WINDOW];
  logic [tcmat_pkg::WINDOW-1:0] valid_r;
  tcmat_pkg::row_t            rd_raw_r;
  logic                       rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_raw_r <= mem[req.rd_addr];
    end
  end

  // a row never written since reset reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= valid_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_raw_r : '0;

endmodule

### rtl/tcmat_accum.sv
module tcmat_accum (
  input  logic                   clk,
  input  logic                   rst_n,
  tcmat_sample_if.sink           in_if,
  output tcmat_pkg::ring_req_t   ring_req,
  input  tcmat_pkg::row_t        ring_rd,
  output tcmat_pkg::frame_req_t  frame_req,
  input  logic                   fmt_busy
);

  tcmat_pkg::slot_t  write_slot_r, write_slot_nxt;
  logic              s1_vld_r;
  tcmat_pkg::row_t   s1_row_r;
  tcmat_pkg::slot_t  s1_slot_r;
  tcmat_pkg::total_t fwd_tot_r, rev_tot_r, pha_tot_r;
  tcmat_pkg::total_t fwd_tot_nxt, rev_tot_nxt, pha_tot_nxt;
  logic [tcmat_pkg::CNT_W-1:0] tick_r, tick_nxt;
  logic              frame_due;
  logic              s1_go;
  logic              accept;

  assign frame_due   = (tick_r == tcmat_pkg::CNT_W'(tcmat_pkg::WINDOW));
  // hold the tick only when its report finds the formatter still busy
  assign s1_go       = s1_vld_r && !(frame_due && fmt_busy);
  assign in_if.ready = !s1_vld_r || s1_go;
  assign accept      = in_if.valid && in_if.ready;

  assign write_slot_nxt = (write_slot_r == tcmat_pkg::SLOT_W'(tcmat_pkg::WINDOW - 1)) ?
                          '0 : write_slot_r + 1'b1;

  assign fwd_tot_nxt = fwd_tot_r - tcmat_pkg::total_t'(ring_rd.fwd)
                       + tcmat_pkg::total_t'(s1_row_r.fwd);
  assign rev_tot_nxt = rev_tot_r - tcmat_pkg::total_t'(ring_rd.rev)
                       + tcmat_pkg::total_t'(s1_row_r.rev);
  assign pha_tot_nxt = pha_tot_r - tcmat_pkg::total_t'(ring_rd.pha)
                       + tcmat_pkg::total_t'(s1_row_r.pha);

  assign tick_nxt = frame_due ? tcmat_pkg::CNT_W'(1) : tick_r + 1'b1;

  always_comb begin
    ring_req.rd_en   = accept;
    ring_req.rd_addr = write_slot_r;
    ring_req.wr_en   = s1_go;
    ring_req.wr_addr = s1_slot_r;
    ring_req.wr_data = s1_row_r;
  end

  always_comb begin
    frame_req.valid = s1_go && frame_due;
    frame_req.fwd   = fwd_tot_nxt;
    frame_req.rev   = rev_tot_nxt;
    frame_req.pha   = pha_tot_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_row_r.fwd <= in_if.forward_sample;
      s1_row_r.rev <= in_if.reverse_sample;
      s1_row_r.pha <= in_if.phase_sample;
      s1_slot_r    <= write_slot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r     <= 1'b0;
      write_slot_r <= '0;
      fwd_tot_r    <= '0;
      rev_tot_r    <= '0;
      pha_tot_r    <= '0;
      tick_r       <= '0;
    end else begin
      if (accept) begin
        s1_vld_r     <= 1'b1;
        write_slot_r <= write_slot_nxt;
      end else if (s1_go) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_go) begin
        fwd_tot_r <= fwd_tot_nxt;
        rev_tot_r <= rev_tot_nxt;
        pha_tot_r <= pha_tot_nxt;
        tick_r    <= tick_nxt;
      end
    end
  end

endmodule

### rtl/tcmat_fmt.sv
module tcmat_fmt (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tcmat_pkg::frame_req_t  frame_req,
  output logic                   busy,
  tcmat_frame_if.source          out_if
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MEAN = 4'b0010,
    ST_CONV = 4'b0100,
    ST_SEND = 4'b1000
  } fmt_state_t;

  fmt_state_t state_r;
  tcmat_pkg::total_t tot_r [tcmat_pkg::CHANNELS];
  tcmat_pkg::sample_t bin_r [tcmat_pkg::CHANNELS];
  logic [tcmat_pkg::BCD_W-1:0] bcd_r [tcmat_pkg::CHANNELS];
  logic [tcmat_pkg::PROD_W-1:0] prod [tcmat_pkg::CHANNELS];
  logic [tcmat_pkg::BCD_W-1:0] bcd_adj [tcmat_pkg::CHANNELS];
  logic [tcmat_pkg::BIT_CNT_W-1:0] step_r;
  logic [tcmat_pkg::FRAME_IDX_W-1:0] idx_r;
  logic [7:0] frame_w [tcmat_pkg::FRAME_LEN];
  logic       last_byte;

  function automatic logic [tcmat_pkg::BCD_W-1:0] add3(input logic [tcmat_pkg::BCD_W-1:0] v);
    logic [tcmat_pkg::BCD_W-1:0] r;
    r = v;
    for (int d = 0; d < tcmat_pkg::DIGITS; d++) begin
      if (r[d*4 +: 4] > 4'd4) begin
        r[d*4 +: 4] = r[d*4 +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] chan_tag(input int c);
    logic [7:0] t;
    case (c)
      0:       t = tcmat_pkg::CH_F;
      1:       t = tcmat_pkg::CH_R;
      default: t = tcmat_pkg::CH_P;
    endcase
    return t;
  endfunction

  always_comb begin
    for (int c = 0; c < tcmat_pkg::CHANNELS; c++) begin
      prod[c]    = tcmat_pkg::PROD_W'(tot_r[c]) * tcmat_pkg::PROD_W'(tcmat_pkg::RECIP);
      bcd_adj[c] = add3(bcd_r[c]);
    end
  end

  // frame text: '#' or '*', tag, '=', four digits per channel, then two spaces
  always_comb begin
    for (int c = 0; c < tcmat_pkg::CHANNELS; c++) begin
      frame_w[c*7]     = (c == 0) ? tcmat_pkg::CH_HASH : tcmat_pkg::CH_STAR;
      frame_w[c*7 + 1] = chan_tag(c);
      frame_w[c*7 + 2] = tcmat_pkg::CH_EQ;
      for (int d = 0; d < tcmat_pkg::DIGITS; d++) begin
        frame_w[c*7 + 3 + d] = tcmat_pkg::CH_ZERO +
                               {4'd0, bcd_r[c][(tcmat_pkg::DIGITS-1-d)*4 +: 4]};
      end
    end
    frame_w[tcmat_pkg::FRAME_LEN-2] = tcmat_pkg::CH_SPACE;
    frame_w[tcmat_pkg::FRAME_LEN-1] = tcmat_pkg::CH_SPACE;
  end

  assign last_byte         = (idx_r == tcmat_pkg::FRAME_IDX_W'(tcmat_pkg::FRAME_LEN - 1));
  assign busy              = (state_r != ST_IDLE);
  assign out_if.valid      = (state_r == ST_SEND);
  assign out_if.frame_byte = frame_w[idx_r];
  assign out_if.frame_end  = last_byte;

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (frame_req.valid) begin
          tot_r[0] <= frame_req.fwd;
          tot_r[1] <= frame_req.rev;
          tot_r[2] <= frame_req.pha;
        end
      end
      ST_MEAN: begin
        for (int c = 0; c < tcmat_pkg::CHANNELS; c++) begin
          bin_r[c] <= prod[c][tcmat_pkg::RECIP_SHIFT +: tcmat_pkg::SAMPLE_BITS];
          bcd_r[c] <= '0;
        end
      end
      ST_CONV: begin
        // shift-and-add-3, one binary bit per cycle in each lane
        for (int c = 0; c < tcmat_pkg::CHANNELS; c++) begin
          bcd_r[c] <= {bcd_adj[c][tcmat_pkg::BCD_W-2:0], bin_r[c][tcmat_pkg::SAMPLE_BITS-1]};
          bin_r[c] <= {bin_r[c][tcmat_pkg::SAMPLE_BITS-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      idx_r   <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (frame_req.valid) begin
            state_r <= ST_MEAN;
          end
        end
        ST_MEAN: begin
          step_r  <= tcmat_pkg::BIT_CNT_W'(tcmat_pkg::SAMPLE_BITS - 1);
          state_r <= ST_CONV;
        end
        ST_CONV: begin
          if (step_r == '0) begin
            idx_r   <= '0;
            state_r <= ST_SEND;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        ST_SEND: begin
          if (out_if.ready) begin
            if (last_byte) begin
              state_r <= ST_IDLE;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/three_channel_mean_ascii_telemetry.sv
// Three-channel moving average with an ASCII report. Each accepted request carries a
// forward, reverse and phase sample; the block takes one request per cycle when input
// is not held back. A request is read from the 50-row sample ring when accepted and
// the row is written back, with the running totals, from the stage register after it;
// consecutive requests use consecutive rows, so the two accesses never meet on one
// row. Rows read as zero until first written (a valid bit per row, cleared at reset,
// no clearing pass). The tick that finds the tick counter at 50 (tick 51 after reset,
// then every 50 ticks) starts a report of 23 bytes "#F=dddd*R=dddd*P=dddd" plus two
// spaces, each dddd the channel total divided by 50. The first report byte is offered
// once the totals are divided (ST_MEAN) and converted to BCD bit by bit (ST_CONV),
// then one byte per cycle as the output takes them; the report unit runs alongside
// sample intake. Input is held back only when a report falls due while the previous
// one has not yet been fully taken.
module three_channel_mean_ascii_telemetry (
  input  logic           clk,
  input  logic           rst_n,
  tcmat_sample_if.sink   in_if,
  tcmat_frame_if.source  out_if
);

  tcmat_pkg::ring_req_t  ring_req;
  tcmat_pkg::row_t       ring_rd;
  tcmat_pkg::frame_req_t frame_req;
  logic                  fmt_busy;

  tcmat_ring u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (ring_req),
    .rd_data (ring_rd)
  );

  tcmat_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .ring_req  (ring_req),
    .ring_rd   (ring_rd),
    .frame_req (frame_req),
    .fmt_busy  (fmt_busy)
  );

  tcmat_fmt u_fmt (
    .clk       (clk),
    .rst_n     (rst_n),
    .frame_req (frame_req),
    .busy      (fmt_busy),
    .out_if    (out_if)
  );

endmodule

### sim/tcmat_report_checker.sv
module tcmat_report_checker (
  input  logic        clk,
  input  logic        rst_n,
  tcmat_sample_if     in_if,
  tcmat_frame_if      out_if,
  output int unsigned mismatch_count,
  output int unsigned bytes_outstanding
);
  import tcmat_pkg::*;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } report_beat_t;

  sample_t            fwd_ring [WINDOW];
  sample_t            rev_ring [WINDOW];
  sample_t            pha_ring [WINDOW];
  total_t             fwd_sum;
  total_t             rev_sum;
  total_t             pha_sum;
  slot_t              slot;
  logic [CNT_W-1:0]   ticks;
  report_beat_t       expected_bytes [$];
  int unsigned        bytes_seen;

  // four ascii digits of floor(sum / WINDOW)
  function automatic logic [31:0] mean_text(input total_t sum);
    int unsigned mean;
    mean = sum / WINDOW;
    return {CH_ZERO + 8'((mean / 1000) % 10), CH_ZERO + 8'((mean / 100) % 10),
            CH_ZERO + 8'((mean / 10) % 10), CH_ZERO + 8'(mean % 10)};
  endfunction

  task automatic absorb_tick(input sample_t f, input sample_t r, input sample_t p);
    logic [7:0]  text [FRAME_LEN];
    logic [31:0] fd;
    logic [31:0] rd;
    logic [31:0] pd;
    fwd_sum = fwd_sum - fwd_ring[slot] + total_t'(f);
    rev_sum = rev_sum - rev_ring[slot] + total_t'(r);
    pha_sum = pha_sum - pha_ring[slot] + total_t'(p);
    fwd_ring[slot] = f;
    rev_ring[slot] = r;
    pha_ring[slot] = p;
    slot = (slot == WINDOW - 1) ? '0 : slot + 1'b1;
    // the report includes the samples of this request
    if (ticks == WINDOW) begin
      ticks = '0;
      fd = mean_text(fwd_sum);
      rd = mean_text(rev_sum);
      pd = mean_text(pha_sum);
      text = '{CH_HASH, CH_F, CH_EQ, fd[31:24], fd[23:16], fd[15:8], fd[7:0],
               CH_STAR, CH_R, CH_EQ, rd[31:24], rd[23:16], rd[15:8], rd[7:0],
               CH_STAR, CH_P, CH_EQ, pd[31:24], pd[23:16], pd[15:8], pd[7:0],
               CH_SPACE, CH_SPACE};
      for (int k = 0; k < FRAME_LEN; k++) begin
        expected_bytes.push_back('{text[k], k == FRAME_LEN - 1});
      end
    end
    ticks = ticks + 1'b1;
  endtask

  task automatic note_mismatch(input string what);
    if (mismatch_count < 10) begin
      $display("[%0t] report byte %0d: %s", $time, bytes_seen, what);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    report_beat_t want;
    if (!rst_n) begin
      for (int k = 0; k < WINDOW; k++) begin
        fwd_ring[k] = '0;
        rev_ring[k] = '0;
        pha_ring[k] = '0;
      end
      fwd_sum = '0;
      rev_sum = '0;
      pha_sum = '0;
      slot = '0;
      ticks = '0;
      bytes_seen = 0;
      mismatch_count = 0;
      expected_bytes.delete();
    end else begin
      if (in_if.valid && in_if.ready) begin
        absorb_tick(in_if.forward_sample, in_if.reverse_sample, in_if.phase_sample);
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_bytes.size() == 0) begin
          note_mismatch($sformatf("unexpected byte %h end %b",
                                  out_if.frame_byte, out_if.frame_end));
        end else begin
          want = expected_bytes.pop_front();
          if (out_if.frame_byte !== want.frame_byte) begin
            note_mismatch($sformatf("frame_byte expected %h got %h",
                                    want.frame_byte, out_if.frame_byte));
          end
          if (out_if.frame_end !== want.frame_end) begin
            note_mismatch($sformatf("frame_end expected %b got %b",
                                    want.frame_end, out_if.frame_end));
          end
        end
        bytes_seen++;
      end
    end
    bytes_outstanding <= expected_bytes.size();
  end

endmodule

### sim/testbench.sv
module testbench;
  import tcmat_pkg::*;

  localparam int RANDOM_TICKS = 293;
  localparam int HOLD_OFF     = 400;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 40;

  typedef enum {FILL_UNIFORM, FILL_HIGH, FILL_LOW, FILL_LEVEL} fill_e;
  typedef enum {RX_OPEN, RX_COIN, RX_COMB, RX_SPARSE} rx_mode_e;

  logic clk;
  logic rst_n;

  tcmat_sample_if in_if ();
  tcmat_frame_if  out_if ();

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned ticks_sent;
  int unsigned burst_left;
  int unsigned quiet_cycles;
  bit          held_off;

  three_channel_mean_ascii_telemetry dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  tcmat_report_checker chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_if             (in_if),
    .out_if            (out_if),
    .mismatch_count    (mismatches),
    .bytes_outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // offers one request, then maybe ends the burst with a gap
  task automatic send_tick(input sample_t f, input sample_t r, input sample_t p);
    int unsigned gap;
    in_if.valid          <= 1'b1;
    in_if.forward_sample <= f;
    in_if.reverse_sample <= r;
    in_if.phase_sample   <= p;
    // ready comes from registers only, so mid-cycle it shows the coming edge
    @(negedge clk);
    while (!in_if.ready) @(negedge clk);
    @(posedge clk);
    ticks_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
  endtask

  function automatic sample_t pick_sample(input fill_e fill, input sample_t level);
    case (fill)
      FILL_HIGH: return sample_t'($urandom_range(990, 1023));
      FILL_LOW:  return sample_t'($urandom_range(0, 15));
      FILL_LEVEL: return level;
      default:   return sample_t'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic sample_t pick_level();
    case ($urandom_range(0, 8))
      0: return 10'd0;
      1: return 10'd9;
      2: return 10'd10;
      3: return 10'd99;
      4: return 10'd100;
      5: return 10'd999;
      6: return 10'd1000;
      7: return 10'd1023;
      default: return sample_t'($urandom_range(0, 1023));
    endcase
  endfunction

  initial begin
    fill_e   fill;
    sample_t lvl_f;
    sample_t lvl_r;
    sample_t lvl_p;
    rst_n                <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.forward_sample <= '0;
    in_if.reverse_sample <= '0;
    in_if.phase_sample   <= '0;
    ticks_sent = 0;
    burst_left = $urandom_range(1, 30);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_tick(10'd0, 10'd0, 10'd0);
    send_tick(10'd1023, 10'd1023, 10'd1023);
    send_tick(10'd1023, 10'd0, 10'd0);
    send_tick(10'd0, 10'd1023, 10'd0);
    send_tick(10'd0, 10'd0, 10'd1023);
    for (int k = 0; k < SAMPLE_BITS; k++) begin
      send_tick(sample_t'(1) << k, ~(sample_t'(1) << k),
                sample_t'(1) << ((k + 5) % SAMPLE_BITS));
    end
    send_tick(10'd512, 10'd511, 10'd1);
    send_tick(10'd1000, 10'd999, 10'd100);

    fill  = FILL_UNIFORM;
    lvl_f = '0;
    lvl_r = '0;
    lvl_p = '0;
    repeat (RANDOM_TICKS) begin
      // a new fill starts exactly where the next report window starts
      if (ticks_sent % WINDOW == 1) begin
        fill  = fill_e'($urandom_range(0, 3));
        lvl_f = pick_level();
        lvl_r = pick_level();
        lvl_p = pick_level();
      end
      send_tick(pick_sample(fill, lvl_f), pick_sample(fill, lvl_r),
                pick_sample(fill, lvl_p));
    end
    in_if.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("three_channel_mean_ascii_telemetry test passed");
    end else begin
      $display("three_channel_mean_ascii_telemetry test failed");
    end
    $finish;
  end

  // result side stalls on its own schedule, with one long hold-off
  initial begin
    rx_mode_e    mode;
    int unsigned span;
    int unsigned phase;
    held_off = 1'b0;
    phase    = 0;
    out_if.ready <= 1'b0;
    wait (rst_n);
    forever begin
      if (!held_off && ticks_sent >= 130) begin
        held_off = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(5, 60);
      repeat (span) begin
        case (mode)
          RX_OPEN:   out_if.ready <= 1'b1;
          RX_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
          RX_COMB:   out_if.ready <= (phase % 3 != 0);
          RX_SPARSE: out_if.ready <= ($urandom_range(0, 7) == 0);
          default:   out_if.ready <= 1'b1;
        endcase
        phase++;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("three_channel_mean_ascii_telemetry test failed");
        $finish;
      end
    end
  end

endmodule

### filelist.f
rtl/tcmat_pkg.sv
rtl/tcmat_if.sv
rtl/tcmat_ring.sv
rtl/tcmat_accum.sv
rtl/tcmat_fmt.sv
rtl/three_channel_mean_ascii_telemetry.sv
sim/tcmat_report_checker.sv
sim/testbench.sv
